[hw/rtl/ard_sqexp_kernel_macros.svh]
// Assertion macros used by the kernel engine checker.
`ifndef ARD_SQEXP_KERNEL_MACROS_SVH
`define ARD_SQEXP_KERNEL_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/ask_pkg.sv]
// Package with types, constants and the power-of-two table of the kernel engine.
`timescale 1ns / 1ps
package ask_pkg;

  localparam int unsigned PointsDefault = 256;
  localparam int unsigned DimsDefault   = 4;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegWeight0   = 3'd0,
    RegWeight1   = 3'd1,
    RegWeight2   = 3'd2,
    RegWeight3   = 3'd3,
    RegAmplitude = 3'd4,
    RegDiagNoise = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    FuncStore = 1'b0,
    FuncQuery = 1'b1
  } func_e;

  typedef struct packed {
    logic              func;
    logic [7:0]        first_index;
    logic [7:0]        second_index;
    logic signed [15:0] coord_0;
    logic signed [15:0] coord_1;
    logic signed [15:0] coord_2;
    logic signed [15:0] coord_3;
  } in_item_t;

  typedef struct packed {
    logic [31:0] kernel_value;
    logic        is_diagonal;
  } out_item_t;

  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [49:0] ExpCut   = 50'd32 << 24;

  // 2^(-k/16) in Q1.16, rounded to nearest.
  function automatic logic [16:0] pow2_tab(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/ard_sqexp_kernel.sv]
// Squared-exponential ARD kernel engine: point memory and pipelined kernel datapath.
//
//  Channel  | Direction | Handshake              | Payload
//  in       | input     | in_valid_i/in_stall_o  | in_data_i  (ask_pkg::in_item_t)
//  out      | output    | out_valid_o/out_stall_i| out_data_o (ask_pkg::out_item_t)
//  cfg      | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One item can enter in every cycle unless in_stall_o is high; a query result leaves the last pipeline register.
// The rate is set by the dual-read point memory and the nine-stage datapath.
// A stalled result moves into a skid register; while that register is full the whole
// pipeline holds and the input is stalled, so no combinational path runs from out_stall_i.
// Reset clears valid bits and sets the configuration to its defaults; the point memory is not cleared.
`timescale 1ns / 1ps
module ard_sqexp_kernel #(
  parameter int unsigned POINTS = ask_pkg::PointsDefault,
  parameter int unsigned DIMS   = ask_pkg::DimsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ask_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ask_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [ask_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ask_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int unsigned NS = 9;
  localparam int unsigned WrapShift = 24;
  localparam longint unsigned WrapRecip = ((64'd1 << WrapShift) + POINTS - 1) / POINTS;

  // Configuration registers.
  logic [15:0] weight_q [4];
  logic [31:0] amp_q, noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < 4; d++) weight_q[d] <= 16'd4096;
      amp_q   <= 32'd65536;
      noise_q <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ask_pkg::RegWeight0:   weight_q[0] <= cfg_data_i[15:0];
        ask_pkg::RegWeight1:   weight_q[1] <= cfg_data_i[15:0];
        ask_pkg::RegWeight2:   weight_q[2] <= cfg_data_i[15:0];
        ask_pkg::RegWeight3:   weight_q[3] <= cfg_data_i[15:0];
        ask_pkg::RegAmplitude: amp_q       <= cfg_data_i;
        ask_pkg::RegDiagNoise: noise_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance: every stage moves together unless the skid register is full.
  logic [NS-1:0] vld_q;
  logic          skid_vld_q, skid_vld_d;
  logic          adv;
  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  logic acc;
  assign acc = in_valid_i && adv;

  // Index wrap: modulo POINTS by reciprocal multiplication, exact for 8-bit indices.
  function automatic logic [AW-1:0] wrap_idx(input logic [7:0] a);
    logic [31:0] q, r;
    q = 32'((40'(a) * 40'(WrapRecip)) >> WrapShift);
    r = 32'(a) - q * 32'(POINTS);
    return r[AW-1:0];
  endfunction

  logic [AW-1:0] ai, aj;
  assign ai = wrap_idx(in_data_i.first_index);
  assign aj = wrap_idx(in_data_i.second_index);

  // Point memory: one write port, two registered read ports.
  logic [63:0] mem [POINTS];
  logic [63:0] pi_q, pj_q;

  always_ff @(posedge clk_i) begin
    if (acc && in_data_i.func == ask_pkg::FuncStore) begin
      mem[ai] <= {in_data_i.coord_3, in_data_i.coord_2,
                  in_data_i.coord_1, in_data_i.coord_0};
    end
    if (adv) begin
      pi_q <= mem[ai];
      pj_q <= mem[aj];
    end
  end

  // Stage 1: memory read, diagonal flag.
  logic s1_diag_q;
  always_ff @(posedge clk_i) if (adv) s1_diag_q <= (ai == aj);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NS-2:0], acc && in_data_i.func == ask_pkg::FuncQuery};
  end

  // Stage 2: absolute differences.
  logic [16:0] mag_q [4];
  logic        s2_diag_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int d = 0; d < 4; d++) begin
        logic signed [16:0] df;
        df = 17'(signed'(pi_q[16*d +: 16])) - 17'(signed'(pj_q[16*d +: 16]));
        mag_q[d] <= df[16] ? 17'(-df) : df;
      end
      s2_diag_q <= s1_diag_q;
    end
  end

  // Stage 3: scale by weights; dimensions at or beyond DIMS give zero.
  logic [24:0] t_q [4];
  logic        s3_diag_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int d = 0; d < 4; d++) begin
        logic [32:0] p;
        p = 33'(mag_q[d]) * 33'(weight_q[d]);
        t_q[d] <= (d < DIMS) ? p[32:8] : 25'd0;
      end
      s3_diag_q <= s2_diag_q;
    end
  end

  // Stage 4: squares.
  logic [49:0] sq_q [4];
  logic        s4_diag_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int d = 0; d < 4; d++) sq_q[d] <= 50'(t_q[d]) * 50'(t_q[d]);
      s4_diag_q <= s3_diag_q;
    end
  end

  // Stage 5: sum and range check.
  logic [28:0] s_q;
  logic        big_q, s5_diag_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [51:0] s;
      s = 52'(sq_q[0]) + 52'(sq_q[1]) + 52'(sq_q[2]) + 52'(sq_q[3]);
      big_q     <= s >= 52'(ask_pkg::ExpCut);
      s_q       <= s[28:0];
      s5_diag_q <= s4_diag_q;
    end
  end

  // Stage 6: y = (s*Log2eQ16) >> 25, i.e. s*log2(e) >> 9 (s below 2^29 unless flagged as too large).
  logic [20:0] y_q;
  logic        big6_q, s6_diag_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [45:0] p;
      p = 46'(s_q) * 46'(ask_pkg::Log2eQ16);
      y_q       <= p[45:25];
      big6_q    <= big_q;
      s6_diag_q <= s5_diag_q;
    end
  end

  // Stage 7: table interpolation and shift.
  logic [16:0] e_q;
  logic        s7_diag_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [4:0]  n, k;
      logic [11:0] r;
      logic [16:0] tk, tk1, v;
      logic [28:0] dp;
      n   = y_q[20:16];
      k   = {1'b0, y_q[15:12]};
      r   = y_q[11:0];
      tk  = ask_pkg::pow2_tab(k);
      tk1 = ask_pkg::pow2_tab(k + 5'd1);
      dp  = 29'(tk - tk1) * 29'(r);
      v   = tk - 17'(dp >> 12);
      e_q <= (big6_q || n >= 5'd17) ? 17'd0 : (v >> n);
      s7_diag_q <= s6_diag_q;
    end
  end

  // Stage 8: scale by amplitude.
  logic [32:0] kv_q;
  logic        s8_diag_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [48:0] p;
      p = 49'(amp_q) * 49'(e_q);
      kv_q      <= p[48:16];
      s8_diag_q <= s7_diag_q;
    end
  end

  // Stage 9: diagonal noise with saturation; last pipeline register.
  ask_pkg::out_item_t pipe_out_q, skid_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [33:0] sum;
      sum = 34'(kv_q) + (s8_diag_q ? 34'(noise_q) : 34'd0);
      pipe_out_q.kernel_value <= (sum > 34'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
      pipe_out_q.is_diagonal  <= s8_diag_q;
    end
  end

  // Skid register: catches a stalled result so the pipeline advance has no combinational path from out_stall_i.
  always_comb begin
    if (skid_vld_q) skid_vld_d = out_stall_i;
    else skid_vld_d = vld_q[NS-1] && out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) skid_vld_q <= 1'b0;
    else skid_vld_q <= skid_vld_d;
  end

  always_ff @(posedge clk_i) if (!skid_vld_q) skid_q <= pipe_out_q;

  assign out_valid_o = skid_vld_q || vld_q[NS-1];
  assign out_data_o  = skid_vld_q ? skid_q : pipe_out_q;

endmodule

[hw/rtl/ask_checker.sv]
// Port-level checker for the kernel engine, bound to the top level.
`timescale 1ns / 1ps
`include "ard_sqexp_kernel_macros.svh"
module ask_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ask_pkg::out_item_t out_data_o
);

  // Input is only held back while a result is waiting.
  `ASK_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o)

  // A blocked result stays.
  `ASK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // A valid result carries known data.
  `ASK_ASSERT_IMP(a_out_known, clk_i, rst_ni, out_valid_o, !$isunknown(out_data_o))

  // Handshake outputs are always known outside reset.
  `ASK_ASSERT_IMP(a_ctrl_known, clk_i, rst_ni, 1'b1, !$isunknown({out_valid_o, in_stall_o}))

endmodule

bind ard_sqexp_kernel ask_checker u_ask_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);
